### hdl/gdsf_pkg.sv
// Shared types, constants and the sRGB encode table for the glyph drop-shadow filter.
`default_nettype none

package gdsf_pkg;

  localparam int FrameWidthW     = 9;
  localparam int FrameWidthReset = 3;
  localparam int MinWidth        = 3;
  localparam int DefaultMaxWidth = 256;
  localparam int PixelW          = 8;
  localparam int LineEntryW      = 2 * PixelW;
  localparam int RowCountW       = 2;
  localparam int SumW            = 12;
  localparam int NumW            = 21;
  localparam int RoundHalf       = 2040;
  localparam int AlphaMax        = 255;
  localparam int Recip255        = 257;
  localparam int GrayBigW        = 208;

  typedef struct packed {
    logic [PixelW-1:0] alpha_in;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] alpha_out;
    logic [PixelW-1:0] gray_out;
  } out_item_t;

  typedef logic [255:0][PixelW-1:0] gray_tab_t;

  // G(v) counts the levels d with v^5 * 10761^12 >= 255^5 * (40d+541)^12,
  // an exact integer form of round(255 * srgb_encode(v/255)).
  function automatic gray_tab_t build_gray();
    gray_tab_t            tab;
    logic [GrayBigW-1:0]  rhs [256];
    logic [GrayBigW-1:0]  lhs;
    int                   cnt;
    tab    = '0;
    rhs[0] = '0;
    for (int v = 1; v < 256; v++) begin
      rhs[v] = GrayBigW'(1);
      for (int k = 0; k < 5; k++) rhs[v] = rhs[v] * GrayBigW'(255);
      for (int k = 0; k < 12; k++) rhs[v] = rhs[v] * GrayBigW'(40 * v + 541);
    end
    for (int v = 1; v < 256; v++) begin
      lhs = GrayBigW'(1);
      for (int k = 0; k < 5; k++) lhs = lhs * GrayBigW'(v);
      for (int k = 0; k < 12; k++) lhs = lhs * GrayBigW'(10761);
      cnt = 0;
      for (int d = 1; d < 256; d++) begin
        if (lhs >= rhs[d]) cnt = cnt + 1;
      end
      tab[v] = PixelW'(cnt);
    end
    return tab;
  endfunction

  localparam gray_tab_t GrayTab = build_gray();

endpackage

`default_nettype wire

### hdl/gdsf_line_mem.sv
// Two-line pixel store: one write port, one read port with registered read data.
`default_nettype none

module gdsf_line_mem #(
  parameter int Depth = gdsf_pkg::DefaultMaxWidth,
  parameter int AddrW = $clog2(gdsf_pkg::DefaultMaxWidth),
  parameter int DataW = gdsf_pkg::LineEntryW
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/glyph_drop_shadow_filter_top.sv
// Glyph drop-shadow filter: 3x3 binomial blur of the alpha stream composited under the glyph.
`default_nettype none

// One pixel enters per clock unless in_stall_o holds it, and one result leaves per pixel, in
// raster order over the padded frame (line store read at the taking edge, then blur and
// composite multiply into stage 2, then divide by 4080 into the output register). The single
// line store port pair (one read, one write per pixel) sets the one-pixel-per-clock rate.
// Line store contents are tracked by a fill mark, so no clearing pass is needed after reset.
// The user must write frame_width only while the block is idle; the block does not enforce it.
module glyph_drop_shadow_filter_top #(
  parameter int MAX_WIDTH = gdsf_pkg::DefaultMaxWidth
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire gdsf_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output gdsf_pkg::out_item_t                      out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [gdsf_pkg::FrameWidthW-1:0]    cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int PW   = gdsf_pkg::PixelW;
  localparam int SW   = gdsf_pkg::SumW;
  localparam int NW   = gdsf_pkg::NumW;
  localparam int LW   = gdsf_pkg::LineEntryW;
  localparam int YW   = NW - 4;
  localparam int QW   = PW + 1;
  localparam int RW   = gdsf_pkg::RowCountW;

  // ---------------- configuration ----------------
  logic [gdsf_pkg::FrameWidthW-1:0] fw_q;
  logic [31:0]                      fw_ext;
  logic [EW-1:0]                    eff_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= gdsf_pkg::FrameWidthW'(gdsf_pkg::FrameWidthReset);
    end else if (cfg_valid_i) begin
      fw_q <= cfg_data_i;
    end
  end

  always_comb begin
    fw_ext = 32'(fw_q);
    if (fw_ext < 32'(gdsf_pkg::MinWidth)) begin
      eff_w = EW'(gdsf_pkg::MinWidth);
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(fw_ext);
    end
  end

  // ---------------- handshake ----------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_ready, ready2, ready1, adv1, adv2, accept;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign adv2       = s2_v_q && out_ready;
  assign ready2     = !s2_v_q || out_ready;
  assign adv1       = s1_v_q && ready2;
  assign ready1     = !s1_v_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;

  // ---------------- stage 0: position tracking ----------------
  logic [ColW-1:0] col_q, col_d, col_raw, col;
  logic [RW-1:0]   row_q, row_d, row;
  logic [EW-1:0]   col_inc;
  logic [EW-1:0]   fill_q, fill_d;
  logic            start, row_end;

  always_comb begin
    start   = in_data_i.frame_start;
    col_raw = start ? '0 : col_q;
    row     = start ? '0 : row_q;
    // a width lowered mid-row ends the row before this pixel
    col     = (EW'(col_raw) >= eff_w) ? '0 : col_raw;
    col_inc = EW'(col) + EW'(1);
    row_end = (col_inc >= eff_w);
    col_d   = row_end ? '0 : col_inc[ColW-1:0];
    row_d   = (row_end && (row != RW'(2))) ? row + RW'(1) : row;
    fill_d  = (col_inc > fill_q) ? col_inc : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
    end
  end

  // ---------------- stage 1: line store and blur ----------------
  logic [PW-1:0]   s1_cur_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_top_en_q, s1_mid_en_q, s1_first_q, s1_rd_ok_q, s1_byp_q;
  logic [LW-1:0]   s1_byp_data_q;
  logic            wr_pend_q;
  logic [LW-1:0]   rd_data, ent, wr_data;

  gdsf_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW),
    .DataW (LW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_pend_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (col),
    .rd_data_o (rd_data)
  );

  // columns at or past the fill mark were never written and read as zero
  assign ent     = s1_byp_q ? s1_byp_data_q : (s1_rd_ok_q ? rd_data : '0);
  assign wr_data = {ent[PW-1:0], s1_cur_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= accept;
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (adv1) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q      <= in_data_i.alpha_in;
      s1_col_q      <= col;
      s1_top_en_q   <= (row == RW'(2));
      s1_mid_en_q   <= (row != '0);
      s1_first_q    <= (col == '0);
      s1_rd_ok_q    <= (EW'(col) < fill_q);
      s1_byp_q      <= wr_pend_q && (s1_col_q == col);
      s1_byp_data_q <= wr_data;
    end
  end

  // window: [row][0] is column col-2, [row][1] is col-1; row 2 is the current row
  logic [PW-1:0] win00_q, win01_q, win10_q, win11_q, win20_q, win21_q;
  logic [PW-1:0] w00, w01, w10, w11, w20, w21, top, mid, inv_p;
  logic [SW-1:0] h0, h1, h2, s_sum;
  logic [NW-1:0] prod, num;

  always_comb begin
    w00   = s1_first_q ? '0 : win00_q;
    w01   = s1_first_q ? '0 : win01_q;
    w10   = s1_first_q ? '0 : win10_q;
    w11   = s1_first_q ? '0 : win11_q;
    w20   = s1_first_q ? '0 : win20_q;
    w21   = s1_first_q ? '0 : win21_q;
    top   = s1_top_en_q ? ent[LW-1:PW] : '0;
    mid   = s1_mid_en_q ? ent[PW-1:0] : '0;
    h0    = SW'(w00) + (SW'(w01) << 1) + SW'(top);
    h1    = SW'(w10) + (SW'(w11) << 1) + SW'(mid);
    h2    = SW'(w20) + (SW'(w21) << 1) + SW'(s1_cur_q);
    s_sum = h0 + (h1 << 1) + h2;
    // p is the glyph pixel to the left (w21); shadow weight is 255 - p
    inv_p = PW'(gdsf_pkg::AlphaMax) - w21;
    prod  = NW'(s_sum) * NW'(inv_p);
    num   = prod + (NW'(w21) << 12) - (NW'(w21) << 4) + NW'(gdsf_pkg::RoundHalf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win00_q <= '0;
      win01_q <= '0;
      win10_q <= '0;
      win11_q <= '0;
      win20_q <= '0;
      win21_q <= '0;
    end else if (adv1) begin
      win00_q <= w01;
      win01_q <= top;
      win10_q <= w11;
      win11_q <= mid;
      win20_q <= w21;
      win21_q <= s1_cur_q;
    end
  end

  // ---------------- stage 2: divide by 4080 ----------------
  logic [NW-1:0] s2_num_q;
  logic [PW-1:0] s2_gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv1) begin
      s2_v_q <= 1'b1;
    end else if (adv2) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_num_q  <= num;
      s2_gray_q <= gdsf_pkg::GrayTab[w21];
    end
  end

  logic [YW-1:0]   y, rem;
  logic [YW+7:0]   y_mul;
  logic [QW-1:0]   q0, q;

  // 4080 = 16 * 255: shift, then y*257 >> 16 is at most one short of y/255
  always_comb begin
    y     = s2_num_q[NW-1:4];
    y_mul = ((YW + 8)'(y) << 8) + (YW + 8)'(y);
    q0    = y_mul[YW+7:16];
    rem   = y - ((YW'(q0) << 8) - YW'(q0));
    q     = (rem >= YW'(gdsf_pkg::AlphaMax)) ? q0 + QW'(1) : q0;
  end

  // ---------------- output register ----------------
  gdsf_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv2) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_q.alpha_out <= q[PW-1:0];
      out_q.gray_out  <= s2_gray_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  a_wr_pend_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> s1_v_q)
    else $error("line store write pending without an item in stage 1");

  a_frame_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.frame_start) |=> (col_q == ColW'(1)))
    else $error("frame start did not restart the column count");

  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != RW'(3))
    else $error("row count passed saturation");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (fill_q <= EW'(MAX_WIDTH)) && (fill_q != '0))
    else $error("fill mark out of range after a pixel");

  a_quotient_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (q <= QW'(gdsf_pkg::AlphaMax)))
    else $error("composite alpha exceeds 255");

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for the glyph drop-shadow filter: directed table, then random frames checked beat by beat.
`timescale 1ns / 100ps

module testbench;

  localparam int RandItems = 600;
  localparam int QuietItems = 120;
  localparam int IdleLimit = 2000;
  localparam int TailCycles = 10;
  localparam int BlurFull = 4080;  // sum of 3x3 binomial weights times 255
  localparam int BlurHalf = 2040;

  typedef enum logic {RowPixel, RowWidth} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [8:0]           width;
    logic [7:0]           alpha;
    logic                 start;
    logic                 typed;
    gdsf_pkg::out_item_t  want;
  } stim_row_t;

  localparam gdsf_pkg::out_item_t AllClear = '0;
  localparam gdsf_pkg::out_item_t FullCover = '{alpha_out: 8'd255, gray_out: 8'd255};
  localparam int NumRows = 27;

  // Opens with no frame start, then a frame start mid-row, width writes below 3 and above
  // the line length, and a narrower width while a row is partly sent.
  localparam stim_row_t DirRows [NumRows] = '{
    '{RowPixel, 9'd0,   8'd0,   1'b0, 1'b1, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd0,   1'b0, 1'b1, FullCover},
    '{RowPixel, 9'd0,   8'd17,  1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd200, 1'b1, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd1,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b1, FullCover},
    '{RowWidth, 9'd0,   8'd0,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b1, 1'b0, AllClear},
    '{RowWidth, 9'd511, 8'd0,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd128, 1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd64,  1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd32,  1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd255, 1'b0, 1'b0, AllClear},
    '{RowWidth, 9'd2,   8'd0,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd8,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd0,   1'b0, 1'b0, AllClear},
    '{RowWidth, 9'd257, 8'd0,   1'b0, 1'b0, AllClear},
    '{RowPixel, 9'd0,   8'd0,   1'b1, 1'b0, AllClear},
    '{RowWidth, 9'd256, 8'd0,   1'b0, 1'b0, AllClear},
    '{RowWidth, 9'd3,   8'd0,   1'b0, 1'b0, AllClear}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  gdsf_pkg::in_item_t               in_data_i;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  gdsf_pkg::out_item_t              out_data_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [gdsf_pkg::FrameWidthW-1:0] cfg_data_i;

  glyph_drop_shadow_filter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow state of the filter
  logic [7:0]            hist_line [0:1][0:255];
  logic [2:0][1:0][7:0]  win;
  int unsigned           col_pos;
  int unsigned           row_seen;
  logic [8:0]            width_reg;
  logic [7:0]            srgb_lut [0:255];
  logic [255:0]          level_pow [0:255];
  logic [255:0]          code_pow;

  gdsf_pkg::out_item_t  shade_q [$];
  gdsf_pkg::out_item_t  head;
  int         bad_beats = 0;
  int         stuck_cycles = 0;
  int         stall_left = 0;
  bit         gaps_on;
  bit         stall_on;
  bit         quiet = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned active_width();
    if (width_reg < 9'd3) return 3;
    if (width_reg > 9'd256) return 256;
    return width_reg;
  endfunction

  function automatic gdsf_pkg::out_item_t shade_pixel(input logic [7:0] cur,
                                                      input logic start);
    int unsigned w, c, up2, up1, s, p, num;
    gdsf_pkg::out_item_t r;
    w = active_width();
    if (start) begin
      col_pos = 0;
      row_seen = 0;
      win = '0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      win = '0;
    end
    c = col_pos;
    up2 = (row_seen >= 2) ? hist_line[1][c] : 0;
    up1 = (row_seen >= 1) ? hist_line[0][c] : 0;
    hist_line[1][c] = hist_line[0][c];
    hist_line[0][c] = cur;
    s = int'(win[0][0]) + 2 * int'(win[0][1]) + up2
      + 2 * (int'(win[1][0]) + 2 * int'(win[1][1]) + up1)
      + int'(win[2][0]) + 2 * int'(win[2][1]) + int'(cur);
    // glyph pixel to the left sits over the shadow
    p = win[2][1];
    num = s * (255 - p) + BlurFull * p;
    r.alpha_out = 8'((num + BlurHalf) / BlurFull);
    r.gray_out = srgb_lut[p];
    win[0][0] = win[0][1];
    win[0][1] = up2[7:0];
    win[1][0] = win[1][1];
    win[1][1] = up1[7:0];
    win[2][0] = win[2][1];
    win[2][1] = cur;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      win = '0;
      if (row_seen < 2) row_seen = row_seen + 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_alpha();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [7:0] a, input logic s, input logic typed,
                            input gdsf_pkg::out_item_t want);
    gdsf_pkg::out_item_t guess;
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{alpha_in: a, frame_start: s};
    do @(posedge clk_i); while (in_stall_o);
    guess = shade_pixel(a, s);
    shade_q.push_back(typed ? want : guess);
    @(negedge clk_i);
  endtask

  // width changes only once the pipe has drained
  task automatic write_width(input logic [8:0] val);
    in_valid_i <= 1'b0;
    while (shade_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni || quiet || !stall_on) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shade_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %h",
                 $time, out_data_o);
        bad_beats = bad_beats + 1;
      end else begin
        head = shade_q.pop_front();
        if (out_data_o.alpha_out !== head.alpha_out) begin
          $display("%0t: alpha_out mismatch: expected %0d, actual %0d",
                   $time, head.alpha_out, out_data_o.alpha_out);
          bad_beats = bad_beats + 1;
        end
        if (out_data_o.gray_out !== head.gray_out) begin
          $display("%0t: gray_out mismatch: expected %0d, actual %0d",
                   $time, head.gray_out, out_data_o.gray_out);
          bad_beats = bad_beats + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned n, w, rows, total, count, mode, sel, rand_sent;
    logic [8:0] wsel;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;

    // sRGB encode levels: level d holds from v^5 * 10761^12 >= 255^5 * (40d+541)^12
    for (int d = 1; d < 256; d++) begin
      level_pow[d] = 256'd1;
      for (int k = 0; k < 5; k++) level_pow[d] = level_pow[d] * 256'd255;
      for (int k = 0; k < 12; k++) level_pow[d] = level_pow[d] * 256'(40 * d + 541);
    end
    srgb_lut[0] = 8'd0;
    n = 0;
    for (int v = 1; v < 256; v++) begin
      code_pow = 256'd1;
      for (int k = 0; k < 5; k++) code_pow = code_pow * 256'(v);
      for (int k = 0; k < 12; k++) code_pow = code_pow * 256'd10761;
      while (n < 255 && code_pow >= level_pow[n + 1]) n = n + 1;
      srgb_lut[v] = 8'(n);
    end

    for (int c = 0; c < 256; c++) begin
      hist_line[0][c] = 8'd0;
      hist_line[1][c] = 8'd0;
    end
    win = '0;
    col_pos = 0;
    row_seen = 0;
    width_reg = 9'(gdsf_pkg::FrameWidthReset);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    gaps_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].kind == RowWidth) write_width(DirRows[i].width);
      else push_pixel(DirRows[i].alpha, DirRows[i].start, DirRows[i].typed, DirRows[i].want);
    end

    rand_sent = 0;
    while (rand_sent < RandItems) begin
      if (rand_sent + QuietItems >= RandItems) quiet = 1'b1;
      sel = $urandom_range(0, 39);
      if (sel == 0) wsel = 9'($urandom_range(0, 2));
      else if (sel == 1) wsel = 9'($urandom_range(257, 511));
      else if (sel == 2) wsel = 9'd256;
      else if (sel == 3) wsel = 9'd3;
      else if (sel < 10) wsel = 9'($urandom_range(4, 40));
      else wsel = 9'($urandom_range(3, 10));
      // the closing stretch runs back to back, so the width stays put there
      if (!quiet) write_width(wsel);
      gaps_on = !quiet && ($urandom_range(0, 3) != 0);
      stall_on = !quiet && ($urandom_range(0, 3) != 0);
      w = active_width();
      repeat ($urandom_range(1, 3)) begin
        rows = $urandom_range(3, 6);
        // wide rows: one to two lines, enough to exercise the full line store
        total = (w > 40) ? w + $urandom_range(0, w) : w * rows;
        mode = $urandom_range(0, 9);
        count = (mode == 1) ? $urandom_range(1, total - 1) : total;
        for (int k = 0; k < count && rand_sent < RandItems; k++) begin
          if (rand_sent + QuietItems >= RandItems) quiet = 1'b1;
          if (mode == 0)
            push_pixel(rand_alpha(), $urandom_range(0, 7) == 0, 1'b0, AllClear);
          else
            push_pixel((k / w < rows - 2 && k % w < w - 2) ? rand_alpha() : 8'd0,
                       k == 0, 1'b0, AllClear);
          rand_sent = rand_sent + 1;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (shade_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (bad_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
